/* hdl/sfx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_pkg
// Shared constants, state codes and the base-2 fraction table of the
// fixed-point softmax unit.
// ----------------------------------------------------------------------------
package sfx_pkg;

    localparam int MAX_VOCAB     = 64;
    localparam int IDX_W         = $clog2(MAX_VOCAB);
    localparam int CNT_W         = IDX_W + 1;
    localparam int LOGIT_W       = 16;
    localparam int EXP_W         = 17;
    localparam int SUM_W         = 23;
    localparam int RECIP_W       = 24;
    localparam int PROD_W        = EXP_W + RECIP_W;
    localparam int DIV_STEPS     = 40;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam logic [14:0] LOG2E_Q14 = 15'd23637;
    localparam logic [8:0]  EXP_ZERO_SHIFT = 9'd17;

    localparam logic [0:0] ADDR_VOCAB = 1'b0;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SUM_RD,
        ST_SUM_START,
        ST_SUM_WAIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT_RD,
        ST_EMIT_START,
        ST_EMIT_WAIT,
        ST_EMIT_FORM,
        ST_OUT
    } state_t;

    // 2^(-k/16) in Q1.16
    function automatic logic [EXP_W-1:0] pow2_tab(input logic [4:0] k);
        logic [EXP_W-1:0] v;
        begin
            unique case (k)
                5'd0:    v = 17'd65536;
                5'd1:    v = 17'd62757;
                5'd2:    v = 17'd60097;
                5'd3:    v = 17'd57549;
                5'd4:    v = 17'd55109;
                5'd5:    v = 17'd52773;
                5'd6:    v = 17'd50535;
                5'd7:    v = 17'd48393;
                5'd8:    v = 17'd46341;
                5'd9:    v = 17'd44376;
                5'd10:   v = 17'd42495;
                5'd11:   v = 17'd40693;
                5'd12:   v = 17'd38968;
                5'd13:   v = 17'd37316;
                5'd14:   v = 17'd35734;
                5'd15:   v = 17'd34219;
                default: v = 17'd32768;
            endcase
            return v;
        end
    endfunction

endpackage

/* hdl/sfx_exp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_exp_unit
// Three-stage exp(-d) unit: scale by log2(e), table plus linear
// interpolation for the fraction, right shift by the integer part.
// ----------------------------------------------------------------------------
module sfx_exp_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sfx_pkg::LOGIT_W-1:0] diff,
    output logic                      done,
    output logic [sfx_pkg::EXP_W-1:0] exp_val
);
    import sfx_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    logic [30:0] y_reg;
    logic [8:0]  n_reg;
    logic [EXP_W-1:0] a_reg;
    logic [11:0] da_reg;
    logic [9:0]  w_reg;
    logic [EXP_W-1:0] e_reg;

    logic [EXP_W-1:0] tab_a, tab_b, diff_ab;
    logic [21:0] interp;
    logic [12:0] interp_r;
    logic [EXP_W-1:0] mant;

    always_comb
    begin
        tab_a    = pow2_tab({1'b0, y_reg[21:18]});
        tab_b    = pow2_tab({1'b0, y_reg[21:18]} + 5'd1);
        diff_ab  = tab_a - tab_b;
        interp   = da_reg * w_reg;
        interp_r = 13'((interp + 22'd512) >> 10);
        mant     = a_reg - {4'b0, interp_r};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg  <= diff * LOG2E_Q14;
        n_reg  <= y_reg[30:22];
        a_reg  <= tab_a;
        da_reg <= diff_ab[11:0];
        w_reg  <= y_reg[17:8];
        if (n_reg >= EXP_ZERO_SHIFT)
            e_reg <= '0;
        else
            e_reg <= mant >> n_reg[4:0];
    end

    assign done    = v3_reg;
    assign exp_val = e_reg;

endmodule

/* hdl/sfx_recip_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_recip_div
// Bit-serial restoring divider for round(2^39 / sum), one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module sfx_recip_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sfx_pkg::SUM_W-1:0]   den,
    output logic                        done,
    output logic [sfx_pkg::RECIP_W-1:0] quot
);
    import sfx_pkg::*;

    logic                 busy_reg, done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [39:0]          num_reg;
    logic [SUM_W-1:0]     rem_reg, den_reg;
    logic [RECIP_W-1:0]   q_reg;
    logic [SUM_W:0]       rem_sh;
    logic                 ge;

    always_comb
    begin
        rem_sh = {rem_reg, num_reg[39]};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // 2^39 plus half the divisor for rounding
            num_reg <= {1'b1, 17'b0, den[SUM_W-1:1]};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[38:0], 1'b0};
            rem_reg <= ge ? SUM_W'(rem_sh - {1'b0, den_reg}) : rem_sh[SUM_W-1:0];
            q_reg   <= {q_reg[RECIP_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* hdl/softmax_fixed_point_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_fixed_point_unit_top
// Fixed-point softmax: loads Q8.8 logits, emits Q0.16 probabilities.
// ----------------------------------------------------------------------------
// Logits are taken one per cycle while loading. On the transfer marked last the
// count is checked against the configured vector length; a mismatch gives a single
// error result. Otherwise the unit makes two passes over the N stored logits with a
// shared 3-stage exp unit (a sum pass, then an emit pass that waits on the output
// handshake for each entry) and runs a bit-serial reciprocal divider in between.
// No logit is accepted while a vector is being worked.
module softmax_fixed_point_unit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] logit
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] probability, [21:16] entry_index, [22] status
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfx_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]          vocab_reg;
    logic [CNT_W-1:0]          count_reg;
    logic signed [LOGIT_W-1:0] max_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [RECIP_W-1:0]        recip_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [LOGIT_W-1:0]        mem [MAX_VOCAB];
    logic [LOGIT_W-1:0]        rdata_reg;
    logic [PROD_W-1:0]         prod_reg;

    logic               out_valid_reg;
    logic [15:0]        out_prob_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_status_reg;
    logic               out_last_reg;

    logic                      in_xfer, out_xfer, cfg_wr;
    logic signed [LOGIT_W-1:0] logit_in, max_new;
    logic [CNT_W-1:0]          cnt_inc;
    logic                      mismatch, idx_last;
    logic                      exp_start, exp_done, div_start, div_done;
    logic [EXP_W-1:0]          exp_val;
    logic [RECIP_W-1:0]        quot;
    logic [SUM_W-1:0]          den;
    logic [PROD_W:0]           prob_round;
    logic [PROD_W-23:0]        prob_shift;

    assign s_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = out_valid_reg && m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ADDR_VOCAB) ? {25'b0, vocab_reg} : 32'b0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_status_reg, out_idx_reg, out_prob_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        logit_in   = signed'(s_tdata);
        max_new    = (logit_in > max_reg) ? logit_in : max_reg;
        cnt_inc    = (count_reg <= CNT_W'(MAX_VOCAB)) ? count_reg + 1'b1 : count_reg;
        mismatch   = (cnt_inc != vocab_reg) || (cnt_inc > CNT_W'(MAX_VOCAB));
        idx_last   = ({1'b0, idx_reg} == count_reg - 1'b1);
        den        = (sum_reg == '0) ? SUM_W'(1) : sum_reg;
        prob_round = {1'b0, prod_reg} + (PROD_W+1)'(1 << 22);
        prob_shift = prob_round[PROD_W:23];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (in_xfer && s_tlast)
                    state_next = mismatch ? ST_OUT : ST_SUM_RD;
            ST_SUM_RD:     state_next = ST_SUM_START;
            ST_SUM_START:  state_next = ST_SUM_WAIT;
            ST_SUM_WAIT:
                if (exp_done)
                    state_next = idx_last ? ST_DIV_START : ST_SUM_RD;
            ST_DIV_START:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_done)
                    state_next = ST_EMIT_RD;
            ST_EMIT_RD:    state_next = ST_EMIT_START;
            ST_EMIT_START: state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
                if (exp_done)
                    state_next = ST_EMIT_FORM;
            ST_EMIT_FORM:  state_next = ST_OUT;
            ST_OUT:
                if (out_xfer)
                    state_next = out_last_reg ? ST_LOAD : ST_EMIT_RD;
            default:       state_next = ST_LOAD;
        endcase
    end

    // unit controls
    always_comb
    begin
        exp_start = (state_reg == ST_SUM_START) || (state_reg == ST_EMIT_START);
        div_start = (state_reg == ST_DIV_START);
    end

    sfx_exp_unit u_exp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (exp_start),
        .diff    (LOGIT_W'(max_reg - signed'(rdata_reg))),
        .done    (exp_done),
        .exp_val (exp_val)
    );

    sfx_recip_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (den),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk)
    begin
        if (in_xfer && (count_reg < CNT_W'(MAX_VOCAB)))
            mem[count_reg[IDX_W-1:0]] <= s_tdata;
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT_WAIT && exp_done)
            prod_reg <= exp_val * recip_reg;
        if (state_reg == ST_EMIT_FORM)
        begin
            out_prob_reg   <= (prob_shift > 19'd65535) ? 16'hFFFF : prob_shift[15:0];
            out_idx_reg    <= idx_reg;
            out_status_reg <= 1'b0;
            out_last_reg   <= idx_last;
        end
        else if (in_xfer && s_tlast && mismatch)
        begin
            out_prob_reg   <= '0;
            out_idx_reg    <= '0;
            out_status_reg <= 1'b1;
            out_last_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            vocab_reg     <= CNT_W'(MAX_VOCAB);
            count_reg     <= '0;
            max_reg       <= {1'b1, {(LOGIT_W-1){1'b0}}};
            sum_reg       <= '0;
            recip_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && paddr[2] == ADDR_VOCAB)
                vocab_reg <= pwdata[CNT_W-1:0];

            unique case (state_reg)
                ST_LOAD:
                    if (in_xfer)
                    begin
                        count_reg <= cnt_inc;
                        max_reg   <= max_new;
                        if (s_tlast)
                        begin
                            idx_reg <= '0;
                            sum_reg <= '0;
                            if (mismatch)
                            begin
                                count_reg     <= '0;
                                max_reg       <= {1'b1, {(LOGIT_W-1){1'b0}}};
                                out_valid_reg <= 1'b1;
                            end
                        end
                    end
                ST_SUM_WAIT:
                    if (exp_done)
                    begin
                        sum_reg <= sum_reg + SUM_W'(exp_val);
                        idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                    end
                ST_DIV_WAIT:
                    if (div_done)
                        recip_reg <= quot;
                ST_EMIT_FORM:
                    out_valid_reg <= 1'b1;
                ST_OUT:
                    if (out_xfer)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            max_reg   <= {1'b1, {(LOGIT_W-1){1'b0}}};
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // no input transfer while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // the block leaves loading right after the last logit
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("still loading after last logit");

    // entry count saturates one past the store depth
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VOCAB + 1))
        else $error("entry count overflow");

endmodule
